[rtl/core/first_fit_segment_allocator_core_macros.svh]
// assertion macros for the segment allocator
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_CORE_MACROS_SVH
// implication checked on every edge outside reset
`define FFSA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ffsa check failed");
// next-cycle implication
`define FFSA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ffsa check failed");
`endif

[rtl/core/ffsa_pkg.sv]
// ----------------------------------------------------------------------------
// ffsa_pkg
// types and constants used by the segment allocator core
// ----------------------------------------------------------------------------
package ffsa_pkg;
  localparam int MEM_WORDS    = 128;
  localparam int MAX_SEGMENTS = 16;
  localparam int WORD_BITS    = 32;
  localparam int AW = $clog2(MEM_WORDS);
  localparam int HW = $clog2(MAX_SEGMENTS);
  localparam int LW = HW + 1;
  localparam int SW = AW + 1;
  localparam logic [LW-1:0] NIL = LW'(MAX_SEGMENTS);

  localparam logic [2:0] OP_ALLOC   = 3'd0;
  localparam logic [2:0] OP_FREE    = 3'd1;
  localparam logic [2:0] OP_WRITE   = 3'd2;
  localparam logic [2:0] OP_READ    = 3'd3;
  localparam logic [2:0] OP_COMPACT = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOMEM     = 2'd1;
  localparam logic [1:0] ST_BADHANDLE = 2'd2;
  localparam logic [1:0] ST_BADARG    = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_AFIND, S_AWALK, S_FWALK, S_RWAIT, S_RDONE,
    S_CWALK, S_CRD, S_CWR, S_DONE
  } state_t;
endpackage

[rtl/core/ffsa_ram.sv]
// ----------------------------------------------------------------------------
// ffsa_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module ffsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // read first, registered read
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

[rtl/core/first_fit_segment_allocator_core.sv]
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_core
// segment table, address-ordered list and word store with first-fit allocate,
// free, handle read/write and compaction
// ----------------------------------------------------------------------------
//  channel | direction | handshake
//  request | in        | in_valid / in_stall
//  result  | out       | out_valid / out_stall
// one request at a time; in_stall is high from accept until its result leaves.
// allocate: probes for a free slot, then tests list gaps, then result.
// free: walks list entries to the handle; write goes through S_RWAIT, read
// through S_RWAIT and S_RDONE, then result; compact moves each word by
// address, read, write, plus a walk step per segment, paced by the single
// word-store port; after reset a clearing pass zeroes all MEM_WORDS words.
module first_fit_segment_allocator_core
  import ffsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        op,
  input  logic [7:0]        req_size,
  input  logic [3:0]        seg_handle,
  input  logic [6:0]        offset,
  input  logic signed [31:0] wdata,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic [3:0]        out_handle,
  output logic [6:0]        out_base,
  output logic signed [31:0] rdata
);
`include "first_fit_segment_allocator_core_macros.svh"

  state_t state, state_next;

  logic [AW-1:0] seg_base [MAX_SEGMENTS];
  logic [SW-1:0] seg_len  [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] seg_live;
  logic [LW-1:0] seg_link [MAX_SEGMENTS];
  logic [LW-1:0] list_head;

  // latched request
  logic [2:0]  r_op;
  logic [7:0]  r_size;
  logic [HW-1:0] r_h;
  logic [6:0]  r_off;
  logic [31:0] r_wd;

  // walk registers
  logic [LW-1:0] cur, prev, slot;
  logic [SW-1:0] prev_end;
  logic [AW:0]   cnt;
  logic [SW-1:0] mv_i;
  logic [WORD_BITS-1:0] mv_word;

  // ram port
  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [WORD_BITS-1:0] ram_wd, ram_rd;

  ffsa_ram #(.WIDTH(WORD_BITS), .DEPTH(MEM_WORDS)) u_store (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd)
  );

  // shared compare unit: gap test for allocate, address check for rw
  logic [HW-1:0] cur_i;
  logic [SW-1:0] limit, gap, cur_end, rw_idx;
  logic fits, rw_ok;
  assign cur_i   = cur[HW-1:0];
  assign cur_end = SW'(seg_base[cur_i]) + seg_len[cur_i];
  assign limit   = (cur != NIL) ? SW'(seg_base[cur_i]) : SW'(MEM_WORDS);
  assign gap     = limit - prev_end;
  assign fits    = (limit >= prev_end) && ({1'b0, gap} >= {1'b0, r_size});
  assign rw_idx  = SW'(seg_base[r_h]) + SW'(r_off);
  assign rw_ok   = (SW'(r_off) < seg_len[r_h]) && (rw_idx < SW'(MEM_WORDS));

  logic in_acc, out_acc;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_DONE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (cnt == (AW+1)'(MEM_WORDS-1)) state_next = S_IDLE;
      S_IDLE: if (in_acc) begin
        case (op)
          OP_ALLOC: state_next = (req_size == 8'd0 || 32'(req_size) > MEM_WORDS)
                                 ? S_DONE : S_AFIND;
          OP_FREE: state_next = (seg_live[seg_handle[HW-1:0]] &&
                                 32'(seg_handle) < MAX_SEGMENTS) ? S_FWALK : S_DONE;
          OP_WRITE, OP_READ: state_next = S_RWAIT;
          OP_COMPACT: state_next = S_CWALK;
          default: state_next = S_DONE;
        endcase
      end
      S_AFIND: if (!seg_live[cnt[HW-1:0]] || cnt == (AW+1)'(MAX_SEGMENTS-1))
                 state_next = seg_live[cnt[HW-1:0]] ? S_DONE : S_AWALK;
      S_AWALK: if (fits || cur == NIL) state_next = S_DONE;
      S_FWALK: if (cur == NIL || cur == {1'b0, r_h}) state_next = S_DONE;
      S_RWAIT: state_next = (seg_live[r_h] && rw_ok && r_op == OP_READ) ? S_RDONE
                                                                        : S_DONE;
      S_RDONE: state_next = S_DONE;
      S_CWALK: begin
        if (cur == NIL) state_next = S_DONE;
        else if (SW'(seg_base[cur_i]) > prev_end && mv_i < seg_len[cur_i])
          state_next = S_CRD;
      end
      S_CRD: state_next = S_CWR;
      S_CWR: state_next = S_CWALK;
      S_DONE: if (out_acc) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // ram port control
  logic [SW-1:0] src, dst;
  assign src = SW'(seg_base[cur_i]) + mv_i;
  assign dst = prev_end + mv_i;
  always_comb begin
    ram_we = 1'b0;
    ram_addr = rw_idx[AW-1:0];
    ram_wd = r_wd[WORD_BITS-1:0];
    case (state)
      S_CLEAR: begin
        ram_we = 1'b1; ram_addr = cnt[AW-1:0]; ram_wd = '0;
      end
      S_RWAIT: ram_we = seg_live[r_h] && rw_ok && r_op == OP_WRITE;
      S_CWALK: ram_addr = src[AW-1:0];
      S_CWR: begin
        ram_we = 1'b1; ram_addr = dst[AW-1:0]; ram_wd = mv_word;
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt <= '0;
      seg_live <= '0;
      list_head <= NIL;
      for (int i = 0; i < MAX_SEGMENTS; i++) begin
        seg_base[i] <= '0; seg_len[i] <= '0; seg_link[i] <= NIL;
      end
    end else begin
      state <= state_next;
      case (state)
        S_CLEAR: cnt <= cnt + 1'b1;
        S_IDLE: if (in_acc) begin
          r_op <= op; r_size <= req_size; r_h <= seg_handle[HW-1:0];
          r_off <= offset; r_wd <= wdata;
          out_handle <= '0; out_base <= '0; rdata <= '0;
          cnt <= '0; cur <= list_head; prev <= NIL; prev_end <= '0; mv_i <= '0;
          // early status for bad size and bad free handle
          status <= (op == OP_ALLOC && (req_size == 8'd0 || 32'(req_size) > MEM_WORDS))
                    ? ST_BADARG
                    : (op == OP_FREE && !seg_live[seg_handle[HW-1:0]]) ? ST_BADHANDLE
                                                                        : ST_OK;
        end
        S_AFIND: begin
          slot <= {1'b0, cnt[HW-1:0]};
          cnt <= cnt + 1'b1;
          if (seg_live[cnt[HW-1:0]] && cnt == (AW+1)'(MAX_SEGMENTS-1))
            status <= ST_NOMEM;
        end
        S_AWALK: begin
          if (fits) begin
            seg_base[slot[HW-1:0]] <= prev_end[AW-1:0];
            seg_len[slot[HW-1:0]]  <= r_size[SW-1:0];
            seg_live[slot[HW-1:0]] <= 1'b1;
            seg_link[slot[HW-1:0]] <= cur;
            if (prev != NIL) seg_link[prev[HW-1:0]] <= slot;
            else list_head <= slot;
            out_handle <= 4'(slot[HW-1:0]);
            out_base <= 7'(prev_end);
          end else if (cur == NIL) status <= ST_NOMEM;
          else begin
            prev_end <= cur_end; prev <= cur; cur <= seg_link[cur_i];
          end
        end
        S_FWALK: begin
          if (cur == NIL || cur == {1'b0, r_h}) begin
            if (cur != NIL) begin
              if (prev != NIL) seg_link[prev[HW-1:0]] <= seg_link[cur_i];
              else list_head <= seg_link[cur_i];
            end
            seg_live[r_h] <= 1'b0;
            seg_link[r_h] <= NIL;
          end else begin
            prev <= cur; cur <= seg_link[cur_i];
          end
        end
        S_RWAIT: begin
          if (!seg_live[r_h]) status <= ST_BADHANDLE;
          else if (!rw_ok) status <= ST_BADARG;
        end
        S_RDONE: rdata <= 32'($signed(ram_rd));
        S_CWALK: if (cur != NIL) begin
          if (SW'(seg_base[cur_i]) > prev_end) begin
            if (mv_i >= seg_len[cur_i]) begin
              seg_base[cur_i] <= prev_end[AW-1:0];
              prev_end <= prev_end + seg_len[cur_i];
              cur <= seg_link[cur_i]; mv_i <= '0;
            end
          end else begin
            prev_end <= cur_end; cur <= seg_link[cur_i]; mv_i <= '0;
          end
        end
        S_CRD: mv_word <= ram_rd;
        S_CWR: mv_i <= mv_i + 1'b1;
        default: ;
      endcase
    end
  end

  `FFSA_ASSERT_IMP(a_busy_stalls, state != S_IDLE, in_stall)
  `FFSA_ASSERT_NXT(a_accept_leaves_idle, in_acc, state != S_IDLE)
  `FFSA_ASSERT_NXT(a_result_held, out_valid && out_stall, out_valid && $stable(status))
  `FFSA_ASSERT_IMP(a_nomem_clean, out_valid && status != ST_OK, rdata == 32'd0)
endmodule
